FILE: rtl/pcxrle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Shared types, constants and helpers of the PCX run-length scanline decoder.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

    localparam int MAX_LINE_BYTES = 4096;
    localparam int MAX_WIDTH      = 8192;
    localparam int MAX_HEIGHT     = 8192;

    // Line store addressing
    localparam int LS_DEPTH = MAX_LINE_BYTES;
    localparam int LS_AW    = $clog2(LS_DEPTH);
    localparam int LS_LANES = 3;

    localparam logic [7:0] RUN_HDR = 8'hC0;

    // Pixel format codes
    localparam logic [1:0] FMT_MONO   = 2'd0;
    localparam logic [1:0] FMT_PLANE4 = 2'd1;
    localparam logic [1:0] FMT_INDEX8 = 2'd2;
    localparam logic [1:0] FMT_RGB    = 2'd3;

    typedef enum logic [1:0] {
        REG_FORMAT = 2'd0,
        REG_BPL    = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_EMIT,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [12:0] row;
        logic [12:0] first_x;
        logic [3:0]  pixel_count;
        logic [63:0] pixel_lanes;
        logic        image_end;
    } t_pix;

    typedef struct packed {
        logic                wr;
        logic [LS_LANES-1:0] lane_we;
        logic                rd;
        logic [LS_AW-1:0]    addr;
        logic [23:0]         wdata;
    } t_ls_req;

    function automatic logic [12:0] clamp_bpl(input logic [12:0] v);
        logic [12:0] r;
        if (v == 13'd0) begin
            r = 13'd1;
        end else if (v > 13'(MAX_LINE_BYTES)) begin
            r = 13'(MAX_LINE_BYTES);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [13:0] clamp_dim(input logic [13:0] v, input logic [13:0] maxv);
        logic [13:0] r;
        if (v == 14'd0) begin
            r = 14'd1;
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: rtl/pcxrle_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcxrle_byte_if
// Compressed byte channel: valid/ready with one encoded byte per transfer.
// ----------------------------------------------------------------------------
interface pcxrle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] encoded_byte;
    logic       start_image;

    modport source (output valid, output encoded_byte, output start_image, input ready);
    modport sink   (input valid, input encoded_byte, input start_image, output ready);
endinterface

FILE: rtl/pcxrle_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcxrle_pix_if
// Decoded pixel channel: valid/ready with up to eight pixel lanes per transfer.
// ----------------------------------------------------------------------------
interface pcxrle_pix_if;
    logic        valid;
    logic        ready;
    logic [12:0] row;
    logic [12:0] first_x;
    logic [3:0]  pixel_count;
    logic [63:0] pixel_lanes;
    logic        last_of_input;
    logic        image_end;

    modport source (output valid, output row, output first_x, output pixel_count,
                    output pixel_lanes, output last_of_input, output image_end,
                    input ready);
    modport sink   (input valid, input row, input first_x, input pixel_count,
                    input pixel_lanes, input last_of_input, input image_end,
                    output ready);
endinterface

FILE: rtl/pcxrle_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcxrle_line_store
// Plane line store: one entry per byte position, one byte lane per earlier plane,
// lane write enables, registered read data.
// ----------------------------------------------------------------------------
module pcxrle_line_store (
    input  logic                i_clk,
    input  pcxrle_pkg::t_ls_req i_req,
    output logic [23:0]         o_rdata
);
    import pcxrle_pkg::*;

    logic [23:0] mem [LS_DEPTH];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            for (int p = 0; p < LS_LANES; p++) begin
                if (i_req.lane_we[p]) begin
                    mem[i_req.addr][8*p +: 8] <= i_req.wdata[8*p +: 8];
                end
            end
        end
        if (i_req.rd) begin
            r_rdata <= mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pcx_rle_scanline_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_scanline_decoder_unit
// PCX run-length decoder: expands runs, merges planes through the line store
// and emits up to eight pixels per decoded line byte.
// ----------------------------------------------------------------------------
// Sequencing: an input byte is taken only in IDLE, so no new byte is accepted
//   until the previous one is fully decoded. Each decoded byte of an earlier
//   plane is written to the line store in STEP; each byte of the last plane
//   passes STEP (line store read), then EMIT (merge) into the output register
//   or the pending hold. FLUSH sends the held result, if any, when the final
//   result does not go straight out. Output stalls hold EMIT and FLUSH.
// Reset: control state and configuration registers return to defaults; the data
//   registers and the line store are not cleared and hold garbage until written.
// ----------------------------------------------------------------------------
module pcx_rle_scanline_decoder_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pcxrle_byte_if.sink         i_byte,
    pcxrle_pix_if.source        o_pix,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import pcxrle_pkg::*;

    // Configuration
    logic [1:0]  r_fmt;
    logic [12:0] r_bpl;
    logic [13:0] r_width;
    logic [13:0] r_height;

    // Control state
    t_state      r_state, n_state;
    logic [5:0]  r_run, n_run;
    logic        r_await, n_await;
    logic [5:0]  r_cnt, n_cnt;
    logic [7:0]  r_val, n_val;
    logic [12:0] r_row, n_row;
    logic [1:0]  r_plane, n_plane;
    logic [11:0] r_byte, n_byte;
    logic        r_fin, n_fin;

    // Pending and output results
    t_pix        r_hold, n_hold;
    logic        r_hold_vld, n_hold_vld;
    t_pix        r_out, n_out;
    logic        r_out_last, n_out_last;
    logic        r_out_vld, n_out_vld;

    t_ls_req     ls_req;
    logic [23:0] ls_rdata;

    pcxrle_line_store u_line_store (
        .i_clk   (i_clk),
        .i_req   (ls_req),
        .o_rdata (ls_rdata)
    );

    // ---------------- configuration port ----------------
    t_reg_idx cfg_idx;
    logic     cfg_wr;

    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_INDEX8;
            r_bpl    <= 13'd1;
            r_width  <= 14'd1;
            r_height <= 14'd1;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FORMAT: r_fmt    <= pwdata[1:0];
                REG_BPL:    r_bpl    <= pwdata[12:0];
                REG_WIDTH:  r_width  <= pwdata[13:0];
                REG_HEIGHT: r_height <= pwdata[13:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FORMAT: prdata = {30'd0, r_fmt};
            REG_BPL:    prdata = {19'd0, r_bpl};
            REG_WIDTH:  prdata = {18'd0, r_width};
            REG_HEIGHT: prdata = {18'd0, r_height};
        endcase
    end

    // ---------------- position and pixel datapath ----------------
    logic [12:0] bpl_c;
    logic [13:0] w_c, h_c;
    logic [2:0]  planes;
    logic        last_plane;
    logic        bit_fmt;

    assign bpl_c   = clamp_bpl(r_bpl);
    assign w_c     = clamp_dim(r_width, 14'(MAX_WIDTH));
    assign h_c     = clamp_dim(r_height, 14'(MAX_HEIGHT));
    assign planes  = (r_fmt == FMT_PLANE4) ? 3'd4 : (r_fmt == FMT_RGB) ? 3'd3 : 3'd1;
    assign last_plane = ({1'b0, r_plane} + 3'd1) >= planes;
    assign bit_fmt = (r_fmt == FMT_MONO) || (r_fmt == FMT_PLANE4);

    // Position advance after one decoded byte
    logic [12:0] nb;
    logic        wrap;
    logic [13:0] nrow;
    logic        row_done;
    logic [11:0] adv_byte;
    logic [1:0]  adv_plane;
    logic [12:0] adv_row;
    logic        adv_fin;
    logic        end_loop;

    assign nb       = {1'b0, r_byte} + 13'd1;
    assign wrap     = nb >= bpl_c;
    assign nrow     = {1'b0, r_row} + 14'd1;
    assign row_done = nrow >= h_c;

    always_comb begin
        adv_byte  = nb[11:0];
        adv_plane = r_plane;
        adv_row   = r_row;
        adv_fin   = 1'b0;
        if (wrap) begin
            adv_byte = '0;
            if (last_plane) begin
                adv_plane = 2'd0;
                adv_row   = nrow[12:0];
                adv_fin   = row_done;
            end else begin
                adv_plane = r_plane + 2'd1;
            end
        end
    end

    assign end_loop = (r_cnt == 6'd1) || adv_fin;

    // Pixel formation from the run byte and the stored planes
    logic [14:0] x_bits;
    logic [14:0] w15;
    logic [14:0] diff;
    logic        visible;
    logic [3:0]  cnt_bits;
    logic [63:0] lanes;
    logic        last_row;
    t_pix        new_pix;

    assign x_bits   = {r_byte, 3'b000};
    assign w15      = {1'b0, w_c};
    assign diff     = w15 - x_bits;
    assign visible  = bit_fmt ? (x_bits < w15) : ({3'b000, r_byte} < w15);
    assign cnt_bits = (diff > 15'd8) ? 4'd8 : diff[3:0];
    assign last_row = nrow == h_c;

    always_comb begin
        lanes = '0;
        if (bit_fmt) begin
            for (int k = 0; k < 8; k++) begin
                if (4'(k) < cnt_bits) begin
                    if (r_fmt == FMT_MONO) begin
                        lanes[8*k] = r_val[7-k];
                    end else begin
                        lanes[8*k]     = ls_rdata[7-k];
                        lanes[8*k + 1] = ls_rdata[15-k];
                        lanes[8*k + 2] = ls_rdata[23-k];
                        lanes[8*k + 3] = r_val[7-k];
                    end
                end
            end
        end else if (r_fmt == FMT_INDEX8) begin
            lanes[7:0] = r_val;
        end else begin
            lanes[23:0] = {r_val, ls_rdata[15:0]};
        end
    end

    always_comb begin
        new_pix.row         = r_row;
        new_pix.pixel_lanes = lanes;
        if (bit_fmt) begin
            new_pix.first_x     = x_bits[12:0];
            new_pix.pixel_count = cnt_bits;
            new_pix.image_end   = last_row && (diff <= 15'd8);
        end else begin
            new_pix.first_x     = {1'b0, r_byte};
            new_pix.pixel_count = 4'd1;
            new_pix.image_end   = last_row && (({3'b000, r_byte} + 15'd1) == w15);
        end
    end

    // ---------------- sequencer ----------------
    logic acc;
    logic out_free;
    logic e_fin, e_await;
    logic [5:0] e_run;

    assign i_byte.ready = (r_state == ST_IDLE);
    assign acc      = i_byte.valid && (r_state == ST_IDLE);
    assign out_free = !r_out_vld || o_pix.ready;
    assign e_fin    = i_byte.start_image ? 1'b0 : r_fin;
    assign e_await  = i_byte.start_image ? 1'b0 : r_await;
    assign e_run    = i_byte.start_image ? 6'd0 : r_run;

    always_comb begin
        n_state    = r_state;
        n_run      = r_run;
        n_await    = r_await;
        n_cnt      = r_cnt;
        n_val      = r_val;
        n_row      = r_row;
        n_plane    = r_plane;
        n_byte     = r_byte;
        n_fin      = r_fin;
        n_hold     = r_hold;
        n_hold_vld = r_hold_vld;
        n_out      = r_out;
        n_out_last = r_out_last;
        n_out_vld  = r_out_vld && !o_pix.ready;

        ls_req.wr      = 1'b0;
        ls_req.rd      = 1'b0;
        ls_req.addr    = r_byte;
        ls_req.wdata   = {3{r_val}};
        ls_req.lane_we = (r_plane == 2'd0) ? 3'b001 : (r_plane == 2'd1) ? 3'b010 : 3'b100;

        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (i_byte.start_image) begin
                        n_row   = '0;
                        n_plane = '0;
                        n_byte  = '0;
                        n_fin   = 1'b0;
                        n_await = 1'b0;
                        n_run   = '0;
                    end
                    if (!e_fin) begin
                        if (e_await) begin
                            n_await = 1'b0;
                            n_run   = '0;
                            n_cnt   = e_run;
                            n_val   = i_byte.encoded_byte;
                            if (e_run != 6'd0) begin
                                n_state = ST_STEP;
                            end
                        end else if (i_byte.encoded_byte >= RUN_HDR) begin
                            n_run   = i_byte.encoded_byte[5:0];
                            n_await = 1'b1;
                        end else begin
                            n_cnt   = 6'd1;
                            n_val   = i_byte.encoded_byte;
                            n_state = ST_STEP;
                        end
                    end
                end
            end
            ST_STEP: begin
                if (last_plane) begin
                    // fetch earlier planes for the merge
                    ls_req.rd = 1'b1;
                    n_state   = ST_EMIT;
                end else begin
                    ls_req.wr = 1'b1;
                    n_byte    = adv_byte;
                    n_plane   = adv_plane;
                    n_row     = adv_row;
                    n_cnt     = r_cnt - 6'd1;
                    if (adv_fin) begin
                        n_fin = 1'b1;
                        n_run = '0;
                    end
                    n_state   = end_loop ? ST_FLUSH : ST_STEP;
                end
            end
            ST_EMIT: begin
                // hold while the pending result cannot move on
                if (!(visible && r_hold_vld && !out_free)) begin
                    n_byte  = adv_byte;
                    n_plane = adv_plane;
                    n_row   = adv_row;
                    n_cnt   = r_cnt - 6'd1;
                    if (adv_fin) begin
                        n_fin = 1'b1;
                        n_run = '0;
                    end
                    n_state = end_loop ? ST_FLUSH : ST_STEP;
                    if (visible) begin
                        if (r_hold_vld) begin
                            n_out      = r_hold;
                            n_out_last = 1'b0;
                            n_out_vld  = 1'b1;
                            n_hold     = new_pix;
                        end else if (end_loop && out_free) begin
                            // final result of this byte: go straight out
                            n_out      = new_pix;
                            n_out_last = 1'b1;
                            n_out_vld  = 1'b1;
                            n_state    = ST_IDLE;
                        end else begin
                            n_hold     = new_pix;
                            n_hold_vld = 1'b1;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_hold_vld) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out      = r_hold;
                    n_out_last = 1'b1;
                    n_out_vld  = 1'b1;
                    n_hold_vld = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_run      <= '0;
            r_await    <= 1'b0;
            r_cnt      <= '0;
            r_row      <= '0;
            r_plane    <= '0;
            r_byte     <= '0;
            r_fin      <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_run      <= n_run;
            r_await    <= n_await;
            r_cnt      <= n_cnt;
            r_row      <= n_row;
            r_plane    <= n_plane;
            r_byte     <= n_byte;
            r_fin      <= n_fin;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_hold     <= n_hold;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_pix.valid         = r_out_vld;
    assign o_pix.row           = r_out.row;
    assign o_pix.first_x       = r_out.first_x;
    assign o_pix.pixel_count   = r_out.pixel_count;
    assign o_pix.pixel_lanes   = r_out.pixel_lanes;
    assign o_pix.last_of_input = r_out_last;
    assign o_pix.image_end     = r_out.image_end;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PCX run-length scanline decoder. A byte driver
// and a pixel monitor run as clocked blocks around the unit; every accepted
// compressed byte is run through a local decoder model whose pixel results
// are compared field by field with the unit's output transfers. Directed
// corner cases come first, then random images over many register settings
// with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import pcxrle_pkg::*;

    localparam int RAND_ITEMS  = 448;
    localparam int TAIL_CYCLES = 300;

    typedef struct {
        logic [7:0] code;
        logic       start;
    } t_enc_item;

    typedef struct {
        logic [12:0] row;
        logic [12:0] first_x;
        logic [3:0]  pixel_count;
        logic [63:0] pixel_lanes;
        logic        last_of_input;
        logic        image_end;
    } t_pix_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pcxrle_byte_if byte_bus ();
    pcxrle_pix_if  pix_bus ();

    pcx_rle_scanline_decoder_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_bus),
        .o_pix   (pix_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Stimulus and expectation stores
    t_enc_item enc_pending_q[$];
    t_pix_item pix_expect_q[$];
    t_pix_item step_pix_q[$];

    // Decoder model: configuration copy
    logic [1:0]  cfg_fmt;
    logic [12:0] cfg_bpl;
    logic [13:0] cfg_width;
    logic [13:0] cfg_height;

    // Decoder model: position and run state
    int unsigned run_left;
    logic [7:0]  run_byte;
    bit          want_value;
    int unsigned cur_row;
    int unsigned cur_plane;
    int unsigned cur_col;
    bit          img_done;
    logic [23:0] plane_mem [MAX_LINE_BYTES];

    logic byte_took;
    int   src_gap;
    int   snk_stall;
    bit   src_idle_on;
    bit   snk_idle_on;

    int n_fail;
    int n_in;
    int n_checked;
    int n_rand;
    int n_settings;

    initial begin : clk_gen
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #(60_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int unsigned limit_reg(input int unsigned v, input int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int unsigned plane_count(input logic [1:0] fmt);
        if (fmt == FMT_PLANE4) return 4;
        if (fmt == FMT_RGB) return 3;
        return 1;
    endfunction

    function automatic int pick_gap(input bit enable);
        int r;
        if (!enable) return 0;
        r = $urandom_range(0, 31);
        if (r < 20) return 0;
        if (r < 30) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void clear_position();
        run_left   = 0;
        run_byte   = 8'h00;
        want_value = 1'b0;
        cur_row    = 0;
        cur_plane  = 0;
        cur_col    = 0;
        img_done   = 1'b0;
    endfunction

    // Place one decoded line byte and turn it into pixels where it completes them.
    function automatic void expand_line_byte(input logic [7:0] b);
        int unsigned planes, eff_bpl, eff_w, eff_h, x, cnt, k, bi;
        bit          last_plane, last_row, in_store;
        logic [23:0] stored;
        logic [63:0] lanes;
        logic [3:0]  v;
        t_pix_item   p;
        planes     = plane_count(cfg_fmt);
        last_plane = (cur_plane + 1) >= planes;
        eff_bpl    = limit_reg(cfg_bpl, MAX_LINE_BYTES);
        eff_w      = limit_reg(cfg_width, MAX_WIDTH);
        eff_h      = limit_reg(cfg_height, MAX_HEIGHT);
        in_store   = cur_col < MAX_LINE_BYTES;
        if (!last_plane) begin
            if (in_store) plane_mem[cur_col][8*cur_plane +: 8] = b;
        end else begin
            stored   = in_store ? plane_mem[cur_col] : 24'h0;
            last_row = (cur_row + 1) == eff_h;
            if (cfg_fmt == FMT_MONO || cfg_fmt == FMT_PLANE4) begin
                x = cur_col * 8;
                if (x < eff_w) begin
                    cnt   = (eff_w - x > 8) ? 8 : eff_w - x;
                    lanes = '0;
                    for (k = 0; k < cnt; k++) begin
                        bi = 7 - k;
                        if (cfg_fmt == FMT_MONO) begin
                            v = {3'b000, b[bi]};
                        end else begin
                            v = {b[bi], stored[16+bi], stored[8+bi], stored[bi]};
                        end
                        lanes[8*k +: 8] = {4'h0, v};
                    end
                    p.row           = 13'(cur_row);
                    p.first_x       = 13'(x);
                    p.pixel_count   = 4'(cnt);
                    p.pixel_lanes   = lanes;
                    p.last_of_input = 1'b0;
                    p.image_end     = last_row && (x + cnt == eff_w);
                    step_pix_q.push_back(p);
                end
            end else begin
                x = cur_col;
                if (x < eff_w) begin
                    if (cfg_fmt == FMT_INDEX8) begin
                        lanes = {56'h0, b};
                    end else begin
                        lanes = {40'h0, b, stored[15:0]};
                    end
                    p.row           = 13'(cur_row);
                    p.first_x       = 13'(x);
                    p.pixel_count   = 4'd1;
                    p.pixel_lanes   = lanes;
                    p.last_of_input = 1'b0;
                    p.image_end     = last_row && (x + 1 == eff_w);
                    step_pix_q.push_back(p);
                end
            end
        end
        cur_col++;
        if (cur_col >= eff_bpl) begin
            cur_col = 0;
            if (last_plane) begin
                cur_plane = 0;
                cur_row++;
                if (cur_row >= eff_h) begin
                    img_done = 1'b1;
                    run_left = 0;
                end
            end else begin
                cur_plane = (cur_plane + 1) & 3;
            end
        end
    endfunction

    // Work out the pixel transfers caused by one accepted compressed byte.
    function automatic void predict_pixels(input logic [7:0] b, input logic start);
        int unsigned cnt, i;
        step_pix_q.delete();
        if (start) clear_position();
        if (img_done) return;
        if (want_value) begin
            cnt        = run_left;
            want_value = 1'b0;
            run_byte   = b;
            run_left   = 0;
            for (i = 0; i < cnt && !img_done; i++) expand_line_byte(run_byte);
        end else if (b >= RUN_HDR) begin
            run_left   = b[5:0];
            want_value = 1'b1;
        end else begin
            expand_line_byte(b);
        end
        if (step_pix_q.size() != 0) step_pix_q[step_pix_q.size()-1].last_of_input = 1'b1;
        foreach (step_pix_q[i]) pix_expect_q.push_back(step_pix_q[i]);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endfunction

    // Output check first, then prediction for the byte taken at this edge.
    always @(posedge i_clk) begin : pix_monitor
        t_pix_item want;
        if (i_rst_n && pix_bus.valid && pix_bus.ready) begin
            if (pix_expect_q.size() == 0) begin
                $error("unexpected pixel transfer: row %0d first_x %0d",
                       pix_bus.row, pix_bus.first_x);
                n_fail++;
            end else begin
                want = pix_expect_q.pop_front();
                check_field("row", want.row, pix_bus.row);
                check_field("first_x", want.first_x, pix_bus.first_x);
                check_field("pixel_count", want.pixel_count, pix_bus.pixel_count);
                check_field("pixel_lanes", want.pixel_lanes, pix_bus.pixel_lanes);
                check_field("last_of_input", want.last_of_input, pix_bus.last_of_input);
                check_field("image_end", want.image_end, pix_bus.image_end);
                n_checked++;
            end
        end
        if (i_rst_n && byte_bus.valid && byte_bus.ready) begin
            predict_pixels(byte_bus.encoded_byte, byte_bus.start_image);
            n_in++;
        end
        byte_took <= i_rst_n && byte_bus.valid && byte_bus.ready;
    end

    always @(negedge i_clk) begin : enc_driver
        t_enc_item nxt;
        if (!i_rst_n) begin
            byte_bus.valid <= 1'b0;
            src_gap        <= 0;
        end else if (byte_bus.valid && !byte_took) begin
            // hold until the transfer completes
        end else if (src_gap > 0) begin
            byte_bus.valid <= 1'b0;
            src_gap        <= src_gap - 1;
        end else if (enc_pending_q.size() != 0) begin
            nxt = enc_pending_q.pop_front();
            byte_bus.valid        <= 1'b1;
            byte_bus.encoded_byte <= nxt.code;
            byte_bus.start_image  <= nxt.start;
            src_gap               <= pick_gap(src_idle_on);
        end else begin
            byte_bus.valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin : pix_sink
        if (!i_rst_n) begin
            pix_bus.ready <= 1'b0;
            snk_stall     <= 0;
        end else if (snk_stall > 0) begin
            pix_bus.ready <= 1'b0;
            snk_stall     <= snk_stall - 1;
        end else begin
            pix_bus.ready <= 1'b1;
            snk_stall     <= pick_gap(snk_idle_on);
        end
    end

    function automatic void add_code(input logic [7:0] code, input logic start);
        t_enc_item e;
        e.code  = code;
        e.start = start;
        enc_pending_q.push_back(e);
    endfunction

    function automatic int pick_run_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r < 3) return 63;
        return $urandom_range(1, 12);
    endfunction

    // One image: mostly literals and runs, some restarts and dangling headers.
    function automatic void queue_image(input longint unsigned need, input int max_items,
                                        output int used);
        longint unsigned made;
        int              r, c;
        bit              first;
        made  = 0;
        used  = 0;
        first = 1'b1;
        while (made < need && used < max_items) begin
            r = $urandom_range(0, 99);
            if (r < 44) begin
                add_code(8'($urandom_range(0, 'hBF)), first);
                made++;
                used++;
            end else if (r < 92) begin
                c = pick_run_len();
                add_code({2'b11, 6'(c)}, first);
                add_code(8'($urandom_range(0, 255)), 1'b0);
                made += c;
                used += 2;
            end else if (r < 96) begin
                add_code(8'($urandom_range(0, 'hBF)), 1'b1);
                made = 1;
                used++;
            end else begin
                add_code({2'b11, 6'(pick_run_len())}, first);
                add_code(8'($urandom_range(0, 'hBF)), 1'b1);
                made = 1;
                used += 2;
            end
            first = 1'b0;
        end
        // trailing bytes, dropped once the image is complete
        repeat ($urandom_range(0, 3)) add_code(8'($urandom()), 1'b0);
    endfunction

    task automatic write_reg(input t_reg_idx idx, input int unsigned value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_FORMAT: cfg_fmt    = value[1:0];
            REG_BPL:    cfg_bpl    = value[12:0];
            REG_WIDTH:  cfg_width  = value[13:0];
            REG_HEIGHT: cfg_height = value[13:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input logic [1:0] fmt, input int unsigned bpl,
                              input int unsigned w, input int unsigned h);
        write_reg(REG_FORMAT, fmt);
        write_reg(REG_BPL, bpl);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        n_settings++;
    endtask

    // Wait until every byte is taken and every pixel transfer has arrived,
    // then let result-free work inside the unit finish.
    task automatic settle();
        while (enc_pending_q.size() != 0 || byte_bus.valid) @(posedge i_clk);
        while (pix_expect_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stim
        int              used, n_phase, n_img, i;
        longint unsigned need;
        int unsigned     bpl, w, h, pix;
        logic [1:0]      fmt;
        byte_bus.valid        = 1'b0;
        byte_bus.encoded_byte = 8'h00;
        byte_bus.start_image  = 1'b0;
        pix_bus.ready         = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        i_rst_n    = 1'b0;
        byte_took  = 1'b0;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        n_fail = 0;
        n_in = 0;
        n_checked = 0;
        n_rand = 0;
        n_settings = 0;
        cfg_fmt    = FMT_INDEX8;
        cfg_bpl    = 13'd1;
        cfg_width  = 14'd1;
        cfg_height = 14'd1;
        clear_position();
        foreach (plane_mem[i]) plane_mem[i] = 24'h0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero-count run, longest run across lines, value at run-header level
        set_config(FMT_INDEX8, 8, MAX_WIDTH, MAX_HEIGHT);
        add_code(RUN_HDR, 1'b1);
        add_code(8'h55, 1'b0);
        add_code(8'hFF, 1'b0);
        add_code(8'hFF, 1'b0);
        add_code(8'hC1, 1'b0);
        add_code(8'hC0, 1'b0);
        add_code(8'hBF, 1'b0);
        settle();

        // mono with a partial last byte, image end, then ignored byte
        set_config(FMT_MONO, 2, 13, 2);
        add_code(8'h00, 1'b1);
        add_code(8'hBF, 1'b0);
        add_code(8'hC2, 1'b0);
        add_code(8'hF0, 1'b0);
        add_code(8'h12, 1'b0);
        settle();

        // 16 colour merge of four planes
        set_config(FMT_PLANE4, 2, 16, 1);
        add_code(8'h80, 1'b1);
        add_code(8'h01, 1'b0);
        add_code(8'h40, 1'b0);
        add_code(8'h02, 1'b0);
        add_code(8'h20, 1'b0);
        add_code(8'h04, 1'b0);
        add_code(8'h10, 1'b0);
        add_code(8'h08, 1'b0);
        settle();

        // plane position left beyond the new format's plane count
        set_config(FMT_PLANE4, 2, 16, 2);
        add_code(8'h11, 1'b1);
        add_code(8'h22, 1'b0);
        add_code(8'h33, 1'b0);
        add_code(8'h44, 1'b0);
        add_code(8'h55, 1'b0);
        add_code(8'h66, 1'b0);
        settle();
        write_reg(REG_FORMAT, FMT_RGB);
        add_code(8'h77, 1'b0);
        add_code(8'h88, 1'b0);
        settle();

        // RGB run spanning all planes with pixels past the width dropped
        set_config(FMT_RGB, 3, 2, 1);
        add_code(8'hC9, 1'b1);
        add_code(8'h7E, 1'b0);
        settle();

        // short line: never reaches the width
        set_config(FMT_INDEX8, 2, 5, 1);
        add_code(8'h10, 1'b1);
        add_code(8'h20, 1'b0);
        settle();

        n_phase = 0;
        while (n_rand < RAND_ITEMS) begin
            fmt = 2'($urandom_range(0, 3));
            if (n_phase == 0) begin
                bpl = 0;
                w   = 0;
                h   = 0;
            end else if (n_phase == 1) begin
                bpl = 8191;
                w   = 16383;
                h   = 16383;
            end else begin
                bpl = $urandom_range(1, 6);
                h   = $urandom_range(1, 4);
                pix = (fmt == FMT_MONO || fmt == FMT_PLANE4) ? bpl * 8 : bpl;
                case ($urandom_range(0, 3))
                    0, 1: w = pix;
                    2: w = $urandom_range(1, pix);
                    default: w = pix + $urandom_range(1, 5);
                endcase
            end
            set_config(fmt, bpl, w, h);
            src_idle_on = ($urandom_range(0, 4) != 0);
            snk_idle_on = ($urandom_range(0, 4) != 0);
            need = longint'(plane_count(fmt)) * limit_reg(bpl, MAX_LINE_BYTES)
                 * limit_reg(h, MAX_HEIGHT);
            n_img = $urandom_range(2, 4);
            for (i = 0; i < n_img && n_rand < RAND_ITEMS; i++) begin
                queue_image(need, (n_phase == 1) ? 40 : 200, used);
                n_rand += used;
                // hold the sender until the unit has drained
                if (n_phase == 2 || $urandom_range(0, 2) == 0) settle();
            end
            settle();
            n_phase++;
        end

        settle();
        $display("Run covered %0d byte transfers (%0d random) over %0d register settings;",
                 n_in, n_rand, n_settings);
        $display("%0d pixel transfers checked, %0d mismatches.", n_checked, n_fail);
        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
